/* src/mer_pkg.sv */
// Shared constants, codes and types of the midpoint ellipse raster core.
package mer_pkg;

   // Decision register width; arithmetic on it wraps modulo 2^DEC_BITS
   localparam int DEC_BITS = 48;
   // Width of the mirrored screen coordinates
   localparam int OUT_BITS = 13;

   // Configuration port geometry
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Centre position after reset
   localparam int CENTER_X_RESET = 320;
   localparam int CENTER_Y_RESET = 240;

   // Register indexes (byte address divided by four)
   localparam logic [0:0] REG_CENTER_X = 1'b0;
   localparam logic [0:0] REG_CENTER_Y = 1'b1;

   // Request operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [19:0] {
      S_IDLE   = 20'h00001,
      S_SQA    = 20'h00002,
      S_SQB    = 20'h00004,
      S_INIT   = 20'h00008,
      S_INIT2  = 20'h00010,
      S_ADV    = 20'h00020,
      S_R1_ACC = 20'h00040,
      S_R1_SE  = 20'h00080,
      S_TST1   = 20'h00100,
      S_TST2   = 20'h00200,
      S_TST3   = 20'h00400,
      S_Q1     = 20'h00800,
      S_Q2     = 20'h01000,
      S_Q3     = 20'h02000,
      S_Q4     = 20'h04000,
      S_Q5     = 20'h08000,
      S_R2_S   = 20'h10000,
      S_R2_SE1 = 20'h20000,
      S_R2_SE2 = 20'h40000,
      S_EMIT   = 20'h80000
   } seq_state_type;

   // Result hand-over from the sequencer to the output register
   typedef struct packed {
      logic load;
      logic point_valid;
      logic last_point;
   } res_ctl_type;

endpackage

/* src/midpoint_ellipse_raster_core.sv */
// Top level of the midpoint ellipse raster core with output register.
//
// Each request gives one point of the first quadrant of an ellipse around the
// configured centre, with its four mirrored screen coordinates; a start
// request loads the semi-axes and gives the top point, each next request the
// following point, and the final point is flagged. All step arithmetic runs
// through one shared multiplier, one product per cycle, under a step sequencer,
// so one request is taken at a time. The finished result waits in an output
// register, so a new request is taken while the previous result is still
// stalled.
module midpoint_ellipse_raster_core #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 11
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [RADIUS_BITS-1:0]               req_semi_axis_x,
   input  logic [RADIUS_BITS-1:0]               req_semi_axis_y,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_point_valid,
   output logic                                 rsp_last_point,
   output logic [RADIUS_BITS-1:0]               rsp_offset_x,
   output logic [RADIUS_BITS-1:0]               rsp_offset_y,
   output logic signed [mer_pkg::OUT_BITS-1:0]  rsp_col_plus,
   output logic signed [mer_pkg::OUT_BITS-1:0]  rsp_col_minus,
   output logic signed [mer_pkg::OUT_BITS-1:0]  rsp_row_plus,
   output logic signed [mer_pkg::OUT_BITS-1:0]  rsp_row_minus,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mer_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [mer_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [mer_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int OUT_BITS = mer_pkg::OUT_BITS;

   logic [COORD_BITS-1:0]  center_x, center_y;
   logic                   seq_idle;
   logic                   req_accept;
   logic                   out_free;
   mer_pkg::res_ctl_type   res_ctl;
   logic [RADIUS_BITS-1:0] res_x, res_y;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       pv_ff, pv_in;
   logic                       last_ff, last_in;
   logic [RADIUS_BITS-1:0]     off_x_ff, off_x_in;
   logic [RADIUS_BITS-1:0]     off_y_ff, off_y_in;
   logic [OUT_BITS-1:0]        col_p_ff, col_p_in;
   logic [OUT_BITS-1:0]        col_m_ff, col_m_in;
   logic [OUT_BITS-1:0]        row_p_ff, row_p_in;
   logic [OUT_BITS-1:0]        row_m_ff, row_m_in;

   mer_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .center_x    (center_x),
      .center_y    (center_y)
   );

   assign req_stall  = !seq_idle;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   mer_seq #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_op     (req_op),
      .req_a      (req_semi_axis_x),
      .req_b      (req_semi_axis_y),
      .out_free   (out_free),
      .seq_idle   (seq_idle),
      .res_ctl    (res_ctl),
      .res_x      (res_x),
      .res_y      (res_y)
   );

   // Load a finished result and mirror it around the centre; drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pv_in        = pv_ff;
      last_in      = last_ff;
      off_x_in     = off_x_ff;
      off_y_in     = off_y_ff;
      col_p_in     = col_p_ff;
      col_m_in     = col_m_ff;
      row_p_in     = row_p_ff;
      row_m_in     = row_m_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (res_ctl.load) begin
         rsp_valid_in = 1'b1;
         pv_in        = res_ctl.point_valid;
         last_in      = res_ctl.last_point;
         off_x_in     = res_x;
         off_y_in     = res_y;
         if (res_ctl.point_valid) begin
            col_p_in = OUT_BITS'(center_x) + OUT_BITS'(res_x);
            col_m_in = OUT_BITS'(center_x) - OUT_BITS'(res_x);
            row_p_in = OUT_BITS'(center_y) + OUT_BITS'(res_y);
            row_m_in = OUT_BITS'(center_y) - OUT_BITS'(res_y);
         end else begin
            col_p_in = '0;
            col_m_in = '0;
            row_p_in = '0;
            row_m_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pv_ff    <= pv_in;
      last_ff  <= last_in;
      off_x_ff <= off_x_in;
      off_y_ff <= off_y_in;
      col_p_ff <= col_p_in;
      col_m_ff <= col_m_in;
      row_p_ff <= row_p_in;
      row_m_ff <= row_m_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_valid = pv_ff;
   assign rsp_last_point  = last_ff;
   assign rsp_offset_x    = off_x_ff;
   assign rsp_offset_y    = off_y_ff;
   assign rsp_col_plus    = $signed(col_p_ff);
   assign rsp_col_minus   = $signed(col_m_ff);
   assign rsp_row_plus    = $signed(row_p_ff);
   assign rsp_row_minus   = $signed(row_m_ff);

endmodule

/* src/mer_mul.sv */
// Shared signed multiplier with registered product.
module mer_mul #(
   parameter int OPA_BITS = 21,
   parameter int OPB_BITS = 25
) (
   input  logic                                clock,
   input  logic                                mul_en,
   input  logic signed [OPA_BITS-1:0]          mul_opa,
   input  logic signed [OPB_BITS-1:0]          mul_opb,
   output logic signed [OPA_BITS+OPB_BITS-1:0] mul_prod
);

   logic signed [OPA_BITS+OPB_BITS-1:0] prod_ff;
   logic signed [OPA_BITS+OPB_BITS-1:0] prod_in;

   // Full-width signed product
   assign prod_in = mul_opa * mul_opb;

   // Hold the product for the following sequencer step
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign mul_prod = prod_ff;

endmodule

/* src/mer_csr.sv */
// Configuration registers for the ellipse centre, APB-style access.
module mer_csr #(
   parameter int COORD_BITS = 11
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mer_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [mer_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [mer_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output logic [COORD_BITS-1:0]                center_x,
   output logic [COORD_BITS-1:0]                center_y
);

   localparam int ADDR_BITS = mer_pkg::CSR_ADDR_BITS;
   localparam int DATA_BITS = mer_pkg::CSR_DATA_BITS;

   logic [COORD_BITS-1:0] center_x_ff, center_x_in;
   logic [COORD_BITS-1:0] center_y_ff, center_y_in;
   logic                  wr_en;
   logic [0:0]            reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[ADDR_BITS-1];

   // Decode the write
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (wr_en) begin
         case (reg_idx)
            mer_pkg::REG_CENTER_X: center_x_in = csr_pwdata[COORD_BITS-1:0];
            mer_pkg::REG_CENTER_Y: center_y_in = csr_pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= COORD_BITS'(mer_pkg::CENTER_X_RESET);
         center_y_ff <= COORD_BITS'(mer_pkg::CENTER_Y_RESET);
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         mer_pkg::REG_CENTER_X: csr_prdata = DATA_BITS'(center_x_ff);
         mer_pkg::REG_CENTER_Y: csr_prdata = DATA_BITS'(center_y_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign center_x = center_x_ff;
   assign center_y = center_y_ff;

endmodule

/* src/mer_seq.sv */
// Step sequencer and decision datapath around the shared multiplier.
module mer_seq #(
   parameter int RADIUS_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_accept,
   input  logic                       req_op,
   input  logic [RADIUS_BITS-1:0]     req_a,
   input  logic [RADIUS_BITS-1:0]     req_b,
   input  logic                       out_free,
   output logic                       seq_idle,
   output mer_pkg::res_ctl_type       res_ctl,
   output logic [RADIUS_BITS-1:0]     res_x,
   output logic [RADIUS_BITS-1:0]     res_y
);

   localparam int R         = RADIUS_BITS;
   localparam int SQ_BITS   = 2 * R;
   localparam int X_BITS    = R + 1;
   localparam int Y_BITS    = R + 2;
   localparam int OPA_BITS  = 2 * R + 1;
   localparam int OPB_BITS  = 2 * R + 5;
   localparam int PROD_BITS = OPA_BITS + OPB_BITS;
   localparam int DEC_BITS  = mer_pkg::DEC_BITS;

   mer_pkg::seq_state_type state_ff, state_in;

   logic                        active_ff, active_in;
   logic                        reg2_ff, reg2_in;
   logic                        pos_ff, pos_in;
   logic [R-1:0]                a_ff, a_in;
   logic [SQ_BITS-1:0]          a2_ff, a2_in;
   logic [SQ_BITS-1:0]          b2_ff, b2_in;
   logic [X_BITS-1:0]           x_ff, x_in;
   logic signed [Y_BITS-1:0]    y_ff, y_in;
   logic [DEC_BITS-1:0]         dec_ff, dec_in;
   logic signed [PROD_BITS-1:0] hold_ff, hold_in;
   logic                        pend_pv_ff, pend_pv_in;
   logic                        pend_last_ff, pend_last_in;
   logic [R-1:0]                pend_x_ff, pend_x_in;
   logic [R-1:0]                pend_y_ff, pend_y_in;

   logic                        mul_en;
   logic signed [OPA_BITS-1:0]  mul_opa;
   logic signed [OPB_BITS-1:0]  mul_opb;
   logic signed [PROD_BITS-1:0] prod;

   logic signed [OPB_BITS-1:0]  xs, ys;
   logic signed [OPB_BITS-1:0]  f_x3, f_x2, f_x1, f_y2, f_y3, f_y1;
   logic signed [OPA_BITS-1:0]  a2w, b2w;
   logic signed [OPB_BITS-1:0]  b2b, sq_opb;
   logic [DEC_BITS-1:0]         prod_dec, prod4;
   logic                        dec_pos, y_nonneg, y_pos, sq_zero;
   logic                        load;

   // Shared multiplier
   mer_mul #(
      .OPA_BITS (OPA_BITS),
      .OPB_BITS (OPB_BITS)
   ) u_mul (
      .clock    (clock),
      .mul_en   (mul_en),
      .mul_opa  (mul_opa),
      .mul_opb  (mul_opb),
      .mul_prod (prod)
   );

   // Step factors from the current point
   assign xs   = $signed(OPB_BITS'(x_ff));
   assign ys   = OPB_BITS'(y_ff);
   assign f_x3 = (xs <<< 1) + OPB_BITS'(3);
   assign f_x2 = (xs <<< 1) + OPB_BITS'(2);
   assign f_x1 = (xs <<< 1) + OPB_BITS'(1);
   assign f_y2 = (ys <<< 1) - OPB_BITS'(2);
   assign f_y3 = (ys <<< 1) - OPB_BITS'(3);
   assign f_y1 = ys - OPB_BITS'(1);
   assign a2w  = $signed(OPA_BITS'(a2_ff));
   assign b2w  = $signed(OPA_BITS'(b2_ff));
   assign b2b  = $signed(OPB_BITS'(b2_ff));
   assign sq_opb = $signed(prod[OPB_BITS-1:0]);

   // Product folded into the decision width, and scaled by four
   assign prod_dec = DEC_BITS'(prod);
   assign prod4    = prod_dec << 2;

   assign dec_pos  = (dec_ff != '0) && !dec_ff[DEC_BITS-1];
   assign y_nonneg = !y_ff[Y_BITS-1];
   assign y_pos    = y_nonneg && (y_ff != '0);
   assign sq_zero  = (a2_ff == '0) && (b2_ff == '0);

   // Select multiplier operands for the current step
   always_comb begin
      mul_en  = 1'b1;
      mul_opa = '0;
      mul_opb = '0;
      case (state_ff)
         mer_pkg::S_SQA: begin
            mul_opa = $signed(OPA_BITS'(a_ff));
            mul_opb = $signed(OPB_BITS'(a_ff));
         end
         mer_pkg::S_SQB: begin
            mul_opa = OPA_BITS'(y_ff);
            mul_opb = ys;
         end
         mer_pkg::S_INIT: begin
            mul_opa = a2w;
            mul_opb = ys;
         end
         mer_pkg::S_ADV: begin
            if (!reg2_ff) begin
               mul_opa = b2w;
               mul_opb = f_x3;
            end else if (dec_pos) begin
               mul_opa = a2w;
               mul_opb = f_y3;
            end else begin
               mul_opa = b2w;
               mul_opb = f_x2;
            end
         end
         mer_pkg::S_R1_ACC: begin
            mul_opa = a2w;
            mul_opb = f_y2;
         end
         mer_pkg::S_TST1: begin
            mul_opa = b2w;
            mul_opb = xs;
         end
         mer_pkg::S_TST2: begin
            mul_opa = a2w;
            mul_opb = ys;
         end
         mer_pkg::S_TST3: begin
            mul_opa = $signed(f_x1[OPA_BITS-1:0]);
            mul_opb = f_x1;
         end
         mer_pkg::S_Q1: begin
            mul_opa = b2w;
            mul_opb = sq_opb;
         end
         mer_pkg::S_Q2: begin
            mul_opa = $signed(f_y1[OPA_BITS-1:0]);
            mul_opb = f_y1;
         end
         mer_pkg::S_Q3: begin
            mul_opa = a2w;
            mul_opb = sq_opb;
         end
         mer_pkg::S_Q4: begin
            mul_opa = a2w;
            mul_opb = b2b;
         end
         mer_pkg::S_R2_SE1: begin
            mul_opa = a2w;
            mul_opb = f_y3;
         end
         default: mul_en = 1'b0;
      endcase
   end

   // Sequence the steps and update the decision
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      reg2_in      = reg2_ff;
      pos_in       = pos_ff;
      a_in         = a_ff;
      a2_in        = a2_ff;
      b2_in        = b2_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dec_in       = dec_ff;
      hold_in      = hold_ff;
      pend_pv_in   = pend_pv_ff;
      pend_last_in = pend_last_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      load         = 1'b0;
      case (state_ff)
         mer_pkg::S_IDLE: begin
            if (req_accept) begin
               if (req_op == mer_pkg::OP_START) begin
                  a_in      = req_a;
                  x_in      = '0;
                  y_in      = $signed(Y_BITS'(req_b));
                  reg2_in   = 1'b0;
                  active_in = 1'b1;
                  state_in  = mer_pkg::S_SQA;
               end else begin
                  state_in = mer_pkg::S_ADV;
               end
            end
         end
         mer_pkg::S_SQA: state_in = mer_pkg::S_SQB;
         mer_pkg::S_SQB: begin
            a2_in    = prod[SQ_BITS-1:0];
            state_in = mer_pkg::S_INIT;
         end
         mer_pkg::S_INIT: begin
            b2_in    = prod[SQ_BITS-1:0];
            state_in = mer_pkg::S_INIT2;
         end
         mer_pkg::S_INIT2: begin
            // region one start: 4b^2 + a^2 - 4a^2*b
            dec_in   = (DEC_BITS'(b2_ff) << 2) + DEC_BITS'(a2_ff) - prod4;
            state_in = mer_pkg::S_ADV;
         end
         mer_pkg::S_ADV: begin
            // latch the pending point, then step past it
            pend_pv_in   = active_ff;
            pend_last_in = 1'b0;
            pend_x_in    = x_ff[R-1:0];
            pend_y_in    = y_ff[R-1:0];
            pos_in       = dec_pos;
            if (!active_ff) begin
               pend_x_in = '0;
               pend_y_in = '0;
               state_in  = mer_pkg::S_EMIT;
            end else if (!reg2_ff) begin
               if (sq_zero) begin
                  active_in    = 1'b0;
                  pend_last_in = 1'b1;
                  state_in     = mer_pkg::S_EMIT;
               end else begin
                  state_in = mer_pkg::S_R1_ACC;
               end
            end else if (dec_pos) begin
               state_in = mer_pkg::S_R2_S;
            end else begin
               state_in = mer_pkg::S_R2_SE1;
            end
         end
         mer_pkg::S_R1_ACC: begin
            dec_in   = dec_ff + prod4;
            x_in     = x_ff + X_BITS'(1);
            state_in = pos_ff ? mer_pkg::S_R1_SE : mer_pkg::S_TST1;
         end
         mer_pkg::S_R1_SE: begin
            dec_in   = dec_ff - prod4;
            y_in     = y_ff - Y_BITS'(1);
            state_in = mer_pkg::S_TST1;
         end
         mer_pkg::S_TST1: state_in = mer_pkg::S_TST2;
         mer_pkg::S_TST2: begin
            hold_in  = prod;
            state_in = mer_pkg::S_TST3;
         end
         mer_pkg::S_TST3: begin
            // stay in region one while b^2*x <= a^2*y
            if (hold_ff <= prod) begin
               state_in = mer_pkg::S_EMIT;
            end else begin
               reg2_in  = 1'b1;
               state_in = mer_pkg::S_Q1;
            end
         end
         mer_pkg::S_Q1: state_in = mer_pkg::S_Q2;
         mer_pkg::S_Q2: begin
            dec_in   = prod_dec;
            state_in = mer_pkg::S_Q3;
         end
         mer_pkg::S_Q3: state_in = mer_pkg::S_Q4;
         mer_pkg::S_Q4: begin
            dec_in   = dec_ff + prod4;
            state_in = mer_pkg::S_Q5;
         end
         mer_pkg::S_Q5: begin
            dec_in       = dec_ff - prod4;
            active_in    = y_nonneg;
            pend_last_in = !y_nonneg;
            state_in     = mer_pkg::S_EMIT;
         end
         mer_pkg::S_R2_S: begin
            dec_in       = dec_ff - prod4;
            y_in         = y_ff - Y_BITS'(1);
            active_in    = y_pos;
            pend_last_in = !y_pos;
            state_in     = mer_pkg::S_EMIT;
         end
         mer_pkg::S_R2_SE1: begin
            dec_in   = dec_ff + prod4;
            x_in     = x_ff + X_BITS'(1);
            state_in = mer_pkg::S_R2_SE2;
         end
         mer_pkg::S_R2_SE2: begin
            dec_in       = dec_ff - prod4;
            y_in         = y_ff - Y_BITS'(1);
            active_in    = y_pos;
            pend_last_in = !y_pos;
            state_in     = mer_pkg::S_EMIT;
         end
         mer_pkg::S_EMIT: begin
            // hand over once the output register is free
            if (out_free) begin
               load     = 1'b1;
               state_in = mer_pkg::S_IDLE;
            end
         end
         default: state_in = mer_pkg::S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mer_pkg::S_IDLE;
         active_ff <= 1'b0;
         reg2_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         reg2_ff   <= reg2_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      a_ff         <= a_in;
      a2_ff        <= a2_in;
      b2_ff        <= b2_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      dec_ff       <= dec_in;
      hold_ff      <= hold_in;
      pend_pv_ff   <= pend_pv_in;
      pend_last_ff <= pend_last_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
   end

   assign seq_idle            = (state_ff == mer_pkg::S_IDLE);
   assign res_ctl.load        = load;
   assign res_ctl.point_valid = pend_pv_ff;
   assign res_ctl.last_point  = pend_last_ff;
   assign res_x               = pend_x_ff;
   assign res_y               = pend_y_ff;

endmodule

/* tb/mer_point_checker.sv */
`timescale 1ns / 1ps
// Result checker for the ellipse raster core: predicts every point and compares it.
module mer_point_checker #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_op,
   input  logic [RADIUS_BITS-1:0]            req_semi_axis_x,
   input  logic [RADIUS_BITS-1:0]            req_semi_axis_y,
   // result channel
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_point_valid,
   input  logic                              rsp_last_point,
   input  logic [RADIUS_BITS-1:0]            rsp_offset_x,
   input  logic [RADIUS_BITS-1:0]            rsp_offset_y,
   input  logic [mer_pkg::OUT_BITS-1:0]      rsp_col_plus,
   input  logic [mer_pkg::OUT_BITS-1:0]      rsp_col_minus,
   input  logic [mer_pkg::OUT_BITS-1:0]      rsp_row_plus,
   input  logic [mer_pkg::OUT_BITS-1:0]      rsp_row_minus,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mer_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [mer_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                              csr_pready,
   // tallies for the test top
   output int                                fail_count,
   output int                                pending,
   output int                                points_checked,
   output int                                idle_replies,
   output int                                ellipse_ends
);

   localparam int OUT_BITS      = mer_pkg::OUT_BITS;
   localparam int DEC_BITS      = mer_pkg::DEC_BITS;
   localparam int CSR_ADDR_BITS = mer_pkg::CSR_ADDR_BITS;
   localparam logic [63:0] DEC_MASK = (64'd1 << DEC_BITS) - 64'd1;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                   point_valid;
      logic                   last_point;
      logic [RADIUS_BITS-1:0] offset_x;
      logic [RADIUS_BITS-1:0] offset_y;
      logic [OUT_BITS-1:0]    col_plus;
      logic [OUT_BITS-1:0]    col_minus;
      logic [OUT_BITS-1:0]    row_plus;
      logic [OUT_BITS-1:0]    row_minus;
   } ellipse_point_type;

   ellipse_point_type expected_points[$];

   // Predictor copy of the centre and of the stepping state
   logic [63:0] centre_col;
   logic [63:0] centre_row;
   logic [63:0] a_sq;
   logic [63:0] b_sq;
   logic [63:0] decision;
   longint      pend_x;
   longint      pend_y;
   logic        in_region_two;
   logic        drawing;

   int fails     = 0;
   int reports   = 0;
   int n_points  = 0;
   int n_idle    = 0;
   int n_ends    = 0;

   // Give the pending point and step ahead to the one after it
   function automatic ellipse_point_type predict_point(input logic op,
         input logic [RADIUS_BITS-1:0] axis_a, input logic [RADIUS_BITS-1:0] axis_b);
      ellipse_point_type pt;
      logic [63:0]    a;
      logic [63:0]    b;
      logic [63:0]    x;
      logic [63:0]    y;
      logic [63:0]    nx;
      logic [63:0]    ny;
      logic           more;
      pt = '0;
      if (op == mer_pkg::OP_START) begin
         a = 64'(axis_a);
         b = 64'(axis_b);
         a_sq = a * a;
         b_sq = b * b;
         pend_x = 0;
         pend_y = longint'(b);
         in_region_two = 1'b0;
         decision = (4 * b_sq - 4 * a_sq * b + a_sq) & DEC_MASK;
         drawing = 1'b1;
      end
      if (!drawing) return pt;

      x = pend_x;
      y = pend_y;
      more = 1'b0;
      if (!in_region_two) begin
         // region one: east, or south-east on a positive decision
         if (a_sq != 0 || b_sq != 0) begin
            if (decision == 0 || decision[DEC_BITS-1]) begin
               decision = decision + 4 * b_sq * (2 * x + 3);
            end else begin
               decision = decision + 4 * b_sq * (2 * x + 3) - 4 * a_sq * (2 * y - 2);
               pend_y = pend_y - 1;
            end
            decision = decision & DEC_MASK;
            pend_x = pend_x + 1;
            if (($signed(b_sq) * pend_x) <= ($signed(a_sq) * pend_y)) begin
               more = 1'b1;
            end else begin
               // cross into region two and seed its decision from the new point
               in_region_two = 1'b1;
               nx = pend_x;
               ny = pend_y;
               decision = (b_sq * (2 * nx + 1) * (2 * nx + 1)
                           + 4 * a_sq * (ny - 1) * (ny - 1)
                           - 4 * a_sq * b_sq) & DEC_MASK;
               more = (pend_y >= 0);
            end
         end
      end else begin
         // region two: south on a positive decision, else south-east
         if (decision != 0 && !decision[DEC_BITS-1]) begin
            decision = decision - 4 * a_sq * (2 * y - 3);
         end else begin
            decision = decision + 4 * b_sq * (2 * x + 2) - 4 * a_sq * (2 * y - 3);
            pend_x = pend_x + 1;
         end
         decision = decision & DEC_MASK;
         pend_y = pend_y - 1;
         more = (pend_y >= 0);
      end
      drawing = more;

      pt.point_valid = 1'b1;
      pt.last_point  = !more;
      pt.offset_x    = x[RADIUS_BITS-1:0];
      pt.offset_y    = y[RADIUS_BITS-1:0];
      pt.col_plus    = OUT_BITS'(centre_col + x);
      pt.col_minus   = OUT_BITS'(centre_col - x);
      pt.row_plus    = OUT_BITS'(centre_row + y);
      pt.row_minus   = OUT_BITS'(centre_row - y);
      return pt;
   endfunction

   always @(posedge clock) begin
      ellipse_point_type want;
      ellipse_point_type got;
      if (reset) begin
         centre_col    = 64'(mer_pkg::CENTER_X_RESET);
         centre_row    = 64'(mer_pkg::CENTER_Y_RESET);
         a_sq          = '0;
         b_sq          = '0;
         decision      = '0;
         pend_x        = 0;
         pend_y        = 0;
         in_region_two = 1'b0;
         drawing       = 1'b0;
      end else begin
         // compare an accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got.point_valid = rsp_point_valid;
            got.last_point  = rsp_last_point;
            got.offset_x    = rsp_offset_x;
            got.offset_y    = rsp_offset_y;
            got.col_plus    = rsp_col_plus;
            got.col_minus   = rsp_col_minus;
            got.row_plus    = rsp_row_plus;
            got.row_minus   = rsp_row_minus;
            if (got.point_valid === 1'b1) n_points++;
            else n_idle++;
            if (got.last_point === 1'b1) n_ends++;
            if (expected_points.size() == 0) begin
               fails++;
               if (reports < REPORT_LIMIT) begin
                  reports++;
                  $display("%0t: result with no request outstanding", $time);
               end
            end else begin
               want = expected_points.pop_front();
               if (got !== want) begin
                  fails++;
                  if (reports < REPORT_LIMIT) begin
                     reports++;
                     $display("%0t: point mismatch (valid last x y colp colm rowp rowm)",
                              $time);
                     $display("   expected %0b %0b %0d %0d %0d %0d %0d %0d",
                              want.point_valid, want.last_point, want.offset_x,
                              want.offset_y, $signed(want.col_plus), $signed(want.col_minus),
                              $signed(want.row_plus), $signed(want.row_minus));
                     $display("   actual   %0b %0b %0d %0d %0d %0d %0d %0d",
                              got.point_valid, got.last_point, got.offset_x,
                              got.offset_y, $signed(got.col_plus), $signed(got.col_minus),
                              $signed(got.row_plus), $signed(got.row_minus));
                  end
               end
            end
         end

         // predict the point for an accepted request
         if (req_valid && !req_stall)
            expected_points.push_back(predict_point(req_op, req_semi_axis_x,
                                                    req_semi_axis_y));

         // track centre register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[CSR_ADDR_BITS-1:2] == mer_pkg::REG_CENTER_X)
               centre_col = 64'(csr_pwdata[COORD_BITS-1:0]);
            else if (csr_paddr[CSR_ADDR_BITS-1:2] == mer_pkg::REG_CENTER_Y)
               centre_row = 64'(csr_pwdata[COORD_BITS-1:0]);
         end
      end

      fail_count     <= fails;
      pending        <= expected_points.size();
      points_checked <= n_points;
      idle_replies   <= n_idle;
      ellipse_ends   <= n_ends;
   end

endmodule

/* tb/midpoint_ellipse_raster_core_tb.sv */
`timescale 1ns / 1ps
// Test top for the midpoint ellipse raster core: stimulus, receiver stalls and verdict.
module midpoint_ellipse_raster_core_tb;

   localparam int RADIUS_BITS    = 10;
   localparam int COORD_BITS     = 11;
   localparam int OUT_BITS       = mer_pkg::OUT_BITS;
   localparam int CSR_ADDR_BITS  = mer_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS  = mer_pkg::CSR_DATA_BITS;
   localparam int AXIS_MAX       = (1 << RADIUS_BITS) - 1;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 30;
   localparam int TAIL_CYCLES    = 40;
   localparam int TIMEOUT_NS     = 1_200_000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_op;
   logic [RADIUS_BITS-1:0]          req_semi_axis_x;
   logic [RADIUS_BITS-1:0]          req_semi_axis_y;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_point_valid;
   logic                            rsp_last_point;
   logic [RADIUS_BITS-1:0]          rsp_offset_x;
   logic [RADIUS_BITS-1:0]          rsp_offset_y;
   logic signed [OUT_BITS-1:0]      rsp_col_plus;
   logic signed [OUT_BITS-1:0]      rsp_col_minus;
   logic signed [OUT_BITS-1:0]      rsp_row_plus;
   logic signed [OUT_BITS-1:0]      rsp_row_minus;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]        csr_paddr;
   logic [CSR_DATA_BITS-1:0]        csr_pwdata;
   logic [CSR_DATA_BITS-1:0]        csr_prdata;
   logic                            csr_pready;

   int fail_count;
   int pending;
   int points_checked;
   int idle_replies;
   int ellipse_ends;

   int             requests_sent  = 0;
   int             burst_left     = 0;
   int             max_gap        = 0;
   int             settings_used  = 1;
   int             holdoff_asked  = 0;
   stall_mode_type stall_mode     = STALL_NONE;

   midpoint_ellipse_raster_core #(
      .RADIUS_BITS(RADIUS_BITS),
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_semi_axis_x(req_semi_axis_x),
      .req_semi_axis_y(req_semi_axis_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_point_valid(rsp_point_valid),
      .rsp_last_point (rsp_last_point),
      .rsp_offset_x   (rsp_offset_x),
      .rsp_offset_y   (rsp_offset_y),
      .rsp_col_plus   (rsp_col_plus),
      .rsp_col_minus  (rsp_col_minus),
      .rsp_row_plus   (rsp_row_plus),
      .rsp_row_minus  (rsp_row_minus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   mer_point_checker #(
      .RADIUS_BITS(RADIUS_BITS),
      .COORD_BITS (COORD_BITS)
   ) point_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_semi_axis_x(req_semi_axis_x),
      .req_semi_axis_y(req_semi_axis_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_point_valid(rsp_point_valid),
      .rsp_last_point (rsp_last_point),
      .rsp_offset_x   (rsp_offset_x),
      .rsp_offset_y   (rsp_offset_y),
      .rsp_col_plus   (rsp_col_plus),
      .rsp_col_minus  (rsp_col_minus),
      .rsp_row_plus   (rsp_row_plus),
      .rsp_row_minus  (rsp_row_minus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .pending        (pending),
      .points_checked (points_checked),
      .idle_replies   (idle_replies),
      .ellipse_ends   (ellipse_ends)
   );

   always #1 clock = ~clock;

   // Receiver: stall on the current pattern, or hold off for a long stretch when asked
   initial begin : receiver
      int holdoff_served;
      int phase;
      holdoff_served = 0;
      phase = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         phase = phase + 1;
         if (holdoff_served != holdoff_asked) begin
            holdoff_served = holdoff_asked;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES - 1) @(posedge clock);
         end else begin
            case (stall_mode)
               STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
               STALL_PERIODIC: rsp_stall <= ((phase % 11) < 4);
               default:        rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // Offer one request, idling first when a burst has run out, and hold it until taken
   task automatic send_item(input logic op, input logic [RADIUS_BITS-1:0] axis_a,
                            input logic [RADIUS_BITS-1:0] axis_b);
      int gap;
      if (burst_left == 0) begin
         gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left = burst_left - 1;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_semi_axis_x <= axis_a;
      req_semi_axis_y <= axis_b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // Start an ellipse and ask for a number of further points
   task automatic draw_ellipse(input logic [RADIUS_BITS-1:0] axis_a,
                               input logic [RADIUS_BITS-1:0] axis_b, input int nexts);
      send_item(mer_pkg::OP_START, axis_a, axis_b);
      repeat (nexts)
         send_item(mer_pkg::OP_NEXT, RADIUS_BITS'($urandom_range(0, AXIS_MAX)),
                   RADIUS_BITS'($urandom_range(0, AXIS_MAX)));
   endtask

   // Stop offering and wait until every predicted point has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready
   task automatic write_centre(input logic [0:0] reg_index,
                               input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Move the centre once the block is idle, and change the traffic shape
   task automatic new_setting(input logic [CSR_DATA_BITS-1:0] col,
                              input logic [CSR_DATA_BITS-1:0] row,
                              input stall_mode_type mode, input int gap);
      drain_results();
      write_centre(mer_pkg::REG_CENTER_X, col);
      write_centre(mer_pkg::REG_CENTER_Y, row);
      stall_mode = mode;
      max_gap = gap;
      settings_used++;
   endtask

   // Mostly whole small ellipses, some cut short, a few large ones, a little noise
   task automatic run_random_phase(input int budget);
      int stop_at;
      int pick;
      int a;
      int b;
      int full;
      int nexts;
      stop_at = requests_sent + budget;
      while (requests_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_item(1'($urandom_range(0, 1)), RADIUS_BITS'($urandom_range(0, AXIS_MAX)),
                      RADIUS_BITS'($urandom_range(0, AXIS_MAX)));
         end else begin
            if (pick < 78) begin
               a = $urandom_range(0, 12);
               b = $urandom_range(0, 12);
            end else if (pick < 93) begin
               a = $urandom_range(0, 60);
               b = $urandom_range(0, 60);
            end else begin
               a = $urandom_range(0, AXIS_MAX);
               b = $urandom_range(0, AXIS_MAX);
            end
            full = a + b + 3;
            if (pick >= 93 || $urandom_range(0, 5) == 0)
               nexts = $urandom_range(0, (full < 40) ? full : 40);
            else
               nexts = full;
            draw_ellipse(RADIUS_BITS'(a), RADIUS_BITS'(b), nexts);
         end
      end
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = mer_pkg::OP_START;
      req_semi_axis_x = '0;
      req_semi_axis_y = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset centre
      stall_mode = STALL_LIGHT;
      max_gap = 3;
      send_item(mer_pkg::OP_NEXT, '0, '0);              // next with nothing in progress
      draw_ellipse('0, '0, 1);                          // both axes zero, then idle
      send_item(mer_pkg::OP_NEXT, RADIUS_BITS'(AXIS_MAX),
                RADIUS_BITS'(AXIS_MAX));                // next ignores its axes
      draw_ellipse(RADIUS_BITS'(AXIS_MAX), RADIUS_BITS'(AXIS_MAX), 2); // largest, abandoned
      draw_ellipse(RADIUS_BITS'(3), RADIUS_BITS'(2), 5);   // start while busy, run past end
      draw_ellipse(RADIUS_BITS'(0), RADIUS_BITS'(3), 4);   // horizontal axis zero
      draw_ellipse(RADIUS_BITS'(5), RADIUS_BITS'(0), 1);   // flat ellipse
      draw_ellipse(RADIUS_BITS'(AXIS_MAX), RADIUS_BITS'(0), 1);
      draw_ellipse(RADIUS_BITS'(0), RADIUS_BITS'(AXIS_MAX), 2);
      draw_ellipse(10'h2AA, 10'h155, 1);
      draw_ellipse(10'h155, 10'h2AA, 1);

      run_random_phase(220);

      // Centre at the origin: negative mirrored coordinates
      new_setting('0, '0, STALL_HEAVY, 6);
      run_random_phase(220);

      // Centre at the far corner, with a long result hold-off mid-phase
      new_setting(COORD_MAX, COORD_MAX, STALL_PERIODIC, 4);
      run_random_phase(130);
      holdoff_asked++;
      run_random_phase(130);

      // Full-width register data, no idling, with a drain pause between two phases
      new_setting($urandom, $urandom, STALL_NONE, 0);
      run_random_phase(130);
      drain_results();
      run_random_phase(130);

      // Random centre
      new_setting($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  STALL_LIGHT, 8);
      run_random_phase(330);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d requests over %0d centre settings, with stalls, gaps,",
               requests_sent, settings_used);
      $display("a long hold-off and drain pauses: %0d points, %0d ellipse ends, %0d idle",
               points_checked, ellipse_ends, idle_replies);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
src/mer_pkg.sv
src/mer_mul.sv
src/mer_csr.sv
src/mer_seq.sv
src/midpoint_ellipse_raster_core.sv
tb/mer_point_checker.sv
tb/midpoint_ellipse_raster_core_tb.sv
